// ===== design/hold_to_cancel_countdown_timer_macros.svh =====
// assertion macros for the countdown timer checker
`ifndef HOLD_TO_CANCEL_COUNTDOWN_TIMER_MACROS_SVH
`define HOLD_TO_CANCEL_COUNTDOWN_TIMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HCTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define HCTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/hctc_pkg.sv =====
// types, codes and helpers shared by the countdown timer files
package hctc_pkg;

  typedef enum logic [2:0] {
    MODE_SETUP     = 3'd0,
    MODE_COUNT     = 3'd1,
    MODE_DISARMING = 3'd2,
    MODE_DISARMED  = 3'd3,
    MODE_ALARM     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    BEEP_NONE  = 2'd0,
    BEEP_CLICK = 2'd1,
    BEEP_COUNT = 2'd2,
    BEEP_ALARM = 2'd3
  } beep_e;

  typedef enum logic [1:0] {
    BTN_A    = 2'd0,
    BTN_B    = 2'd1,
    BTN_C    = 2'd2,
    BTN_NONE = 2'd3
  } btn_e;

  localparam logic [2:0] CFG_DISARM_HOLD = 3'd0;
  localparam logic [2:0] CFG_FLASH_INT   = 3'd1;
  localparam logic [2:0] CFG_LONG_BEEP   = 3'd2;
  localparam logic [2:0] CFG_DEC_HOLD    = 3'd3;
  localparam logic [2:0] CFG_DEC_REPEAT  = 3'd4;

  localparam logic [9:0] SEC_MS  = 10'd1000;
  localparam logic [9:0] FAST_MS = 10'd333;
  localparam logic [5:0] MIN_LIM = 6'd60;

  typedef struct packed {
    logic [15:0] disarm_hold;
    logic [15:0] flash_int;
    logic [15:0] long_beep;
    logic [15:0] dec_hold;
    logic [15:0] dec_repeat;
  } cfg_t;

  typedef struct packed {
    logic        a_down;
    logic        b_down;
    logic        c_down;
    logic        a_pressed;
    logic        b_pressed;
    logic        c_pressed;
  } btn_t;

  typedef struct packed {
    mode_e       mode;
    logic [1:0]  selection;
    logic [4:0]  show_hours;
    logic [5:0]  show_minutes;
    logic [5:0]  show_seconds;
    logic [15:0] disarm_elapsed_ms;
    beep_e       beep_kind;
    logic        speaker_mute;
    logic        flash_on;
  } res_t;

  function automatic logic [15:0] inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [9:0] inc1000(input logic [9:0] v);
    return (v >= SEC_MS) ? SEC_MS : v + 10'd1;
  endfunction

  function automatic logic [5:0] min_up(input logic [5:0] v);
    return (v + 6'd1 >= MIN_LIM) ? 6'd0 : v + 6'd1;
  endfunction

  function automatic logic [5:0] min_down(input logic [5:0] v);
    return (v == 6'd0 || v > MIN_LIM) ? MIN_LIM - 6'd1 : v - 6'd1;
  endfunction

endpackage

// ===== design/hctc_in_if.sv =====
// input channel: one tick beat carrying button levels and press flags
interface hctc_in_if;
  logic valid;
  logic ready;
  logic btn_a_down;
  logic btn_b_down;
  logic btn_c_down;
  logic btn_a_pressed;
  logic btn_b_pressed;
  logic btn_c_pressed;

  modport source (output valid, btn_a_down, btn_b_down, btn_c_down,
                  btn_a_pressed, btn_b_pressed, btn_c_pressed, input ready);
  modport sink (input valid, btn_a_down, btn_b_down, btn_c_down,
                btn_a_pressed, btn_b_pressed, btn_c_pressed, output ready);
endinterface

// ===== design/hctc_out_if.sv =====
// output channel: one result beat per tick
interface hctc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [1:0]  selection;
  logic [4:0]  show_hours;
  logic [5:0]  show_minutes;
  logic [5:0]  show_seconds;
  logic [15:0] disarm_elapsed_ms;
  logic [1:0]  beep_kind;
  logic        speaker_mute;
  logic        flash_on;

  modport source (output valid, mode, selection, show_hours, show_minutes, show_seconds,
                  disarm_elapsed_ms, beep_kind, speaker_mute, flash_on, input ready);
  modport sink (input valid, mode, selection, show_hours, show_minutes, show_seconds,
                disarm_elapsed_ms, beep_kind, speaker_mute, flash_on, output ready);
endinterface

// ===== design/hctc_cfg.sv =====
// configuration register file
module hctc_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_wdata_i,
  output hctc_pkg::cfg_t   cfg_o
);
  import hctc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.disarm_hold <= 16'd5000;
      cfg_q.flash_int   <= 16'd200;
      cfg_q.long_beep   <= 16'd10000;
      cfg_q.dec_hold    <= 16'd500;
      cfg_q.dec_repeat  <= 16'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DISARM_HOLD: cfg_q.disarm_hold <= cfg_wdata_i;
        CFG_FLASH_INT:   cfg_q.flash_int   <= cfg_wdata_i;
        CFG_LONG_BEEP:   cfg_q.long_beep   <= cfg_wdata_i;
        CFG_DEC_HOLD:    cfg_q.dec_hold    <= cfg_wdata_i;
        CFG_DEC_REPEAT:  cfg_q.dec_repeat  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ===== design/hctc_core.sv =====
// timer state and the per-tick update
module hctc_core #(
  parameter int HOUR_LIMIT = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  hctc_pkg::btn_t  btn_i,
  input  hctc_pkg::cfg_t  cfg_i,
  output hctc_pkg::res_t  res_o
);
  import hctc_pkg::*;

  localparam int HW = $clog2(HOUR_LIMIT + 1);
  localparam logic [HW-1:0] HLIM = HW'(HOUR_LIMIT);
  localparam logic [HW-1:0] HMAX = HW'(HOUR_LIMIT - 1);

  mode_e       mode_q, mode_d;
  logic [1:0]  fs_q, fs_d;
  logic [HW-1:0] set_h_q, set_h_d, sav_h_q, sav_h_d, rem_h_q, rem_h_d;
  logic [5:0]  set_m_q, set_m_d, set_s_q, set_s_d;
  logic [5:0]  sav_m_q, sav_m_d, sav_s_q, sav_s_d;
  logic [5:0]  rem_m_q, rem_m_d, rem_s_q, rem_s_d;
  logic [9:0]  sec_q, sec_d;
  logic [9:0]  bs_q [4];
  logic [9:0]  bs_d [4];
  logic        da_q, da_d;
  btn_e        db_q, db_d;
  logic [15:0] de_q, de_d;
  logic        tone_q, tone_d;
  logic [15:0] ae_q, ae_d;
  logic        fp_q, fp_d;
  logic [15:0] fe_q, fe_d;
  logic [15:0] bh_q, bh_d, rep_q, rep_d;

  logic        dec, any, r_nz, r_gt60, r_ge10, r_ge3, s_mod10;
  btn_e        id;
  beep_e       beep;
  logic        mute;

  function automatic logic [HW-1:0] hr_up(input logic [HW-1:0] v);
    return ({1'b0, v} + 1 >= {1'b0, HLIM}) ? '0 : v + HW'(1);
  endfunction

  function automatic logic [HW-1:0] hr_down(input logic [HW-1:0] v);
    return (v == '0 || v > HLIM) ? HMAX : v - HW'(1);
  endfunction

  // remaining time is kept split into h:m:s so no divider is needed
  always_comb begin
    r_nz    = (rem_h_q != '0) || (rem_m_q != '0) || (rem_s_q != '0);
    r_gt60  = (rem_h_q != '0) || (rem_m_q > 6'd1) || (rem_m_q == 6'd1 && rem_s_q != '0);
    r_ge10  = (rem_h_q != '0) || (rem_m_q != '0) || (rem_s_q >= 6'd10);
    r_ge3   = (rem_h_q != '0) || (rem_m_q != '0) || (rem_s_q >= 6'd3);
    s_mod10 = rem_s_q inside {6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50};
  end

  always_comb begin
    mode_d = mode_q; fs_d = fs_q;
    set_h_d = set_h_q; set_m_d = set_m_q; set_s_d = set_s_q;
    sav_h_d = sav_h_q; sav_m_d = sav_m_q; sav_s_d = sav_s_q;
    rem_h_d = rem_h_q; rem_m_d = rem_m_q; rem_s_d = rem_s_q;
    da_d = da_q; db_d = db_q; de_d = de_q;
    tone_d = tone_q; ae_d = ae_q; fp_d = fp_q; fe_d = fe_q;
    beep = BEEP_NONE; mute = 1'b0; dec = 1'b0;
    sec_d = inc1000(sec_q);
    for (int i = 0; i < 4; i++) bs_d[i] = inc1000(bs_q[i]);

    bh_d = bh_q; rep_d = rep_q;
    if (btn_i.b_down) begin
      bh_d = inc16(bh_q);
      if (bh_d >= cfg_i.dec_hold) begin
        if (bh_q < cfg_i.dec_hold) begin
          dec = 1'b1; rep_d = '0;
        end else begin
          rep_d = inc16(rep_q);
          if (rep_d >= cfg_i.dec_repeat) begin
            dec = 1'b1; rep_d = '0;
          end
        end
      end
    end else begin
      bh_d = '0; rep_d = '0;
    end

    any = btn_i.a_down || btn_i.b_down || btn_i.c_down;
    id  = btn_i.a_down ? BTN_A : (btn_i.b_down ? BTN_B : (btn_i.c_down ? BTN_C : BTN_NONE));

    case (mode_q)
      MODE_SETUP: begin
        if (btn_i.a_pressed) begin
          beep = BEEP_CLICK;
          fs_d = (fs_q >= 2'd2) ? 2'd0 : fs_q + 2'd1;
        end
        if (btn_i.b_pressed) begin
          beep = BEEP_CLICK;
          case (fs_d)
            2'd0: set_h_d = hr_up(set_h_d);
            2'd1: set_m_d = min_up(set_m_d);
            2'd2: set_s_d = min_up(set_s_d);
            default: ;
          endcase
        end
        if (dec) begin
          case (fs_d)
            2'd0: set_h_d = hr_down(set_h_d);
            2'd1: set_m_d = min_down(set_m_d);
            2'd2: set_s_d = min_down(set_s_d);
            default: ;
          endcase
        end
        if (btn_i.c_pressed) begin
          beep = BEEP_CLICK;
          if (set_h_d != '0 || set_m_d != '0 || set_s_d != '0) begin
            sav_h_d = set_h_d; sav_m_d = set_m_d; sav_s_d = set_s_d;
            rem_h_d = set_h_d; rem_m_d = set_m_d; rem_s_d = set_s_d;
            mode_d = MODE_COUNT;
            sec_d = '0;
            for (int i = 0; i < 4; i++) bs_d[i] = SEC_MS;
            tone_d = 1'b0;
          end
        end
      end
      MODE_COUNT, MODE_DISARMING: begin
        if (any && !da_q) begin
          beep = BEEP_CLICK;
          da_d = 1'b1; db_d = id; de_d = '0;
          mode_d = MODE_DISARMING;
        end else if (!any && da_q) begin
          da_d = 1'b0; db_d = BTN_NONE; de_d = '0; mode_d = MODE_COUNT;
        end else if (any && da_q) begin
          if (id == db_q) begin
            de_d = inc16(de_q);
            if (de_d >= cfg_i.disarm_hold) begin
              da_d = 1'b0; db_d = BTN_NONE; de_d = '0; mode_d = MODE_DISARMED;
            end
          end else begin
            da_d = 1'b0; db_d = BTN_NONE; de_d = '0; mode_d = MODE_COUNT;
          end
        end
        if (mode_d == MODE_COUNT) begin
          if (r_gt60) begin
            if (rem_s_q == '0 && bs_d[0] >= SEC_MS) begin
              beep = BEEP_COUNT; bs_d[0] = '0;
            end
          end else if (r_ge10) begin
            if (s_mod10 && bs_d[1] >= SEC_MS) begin
              beep = BEEP_COUNT; bs_d[1] = '0;
            end
          end else if (r_ge3) begin
            if (bs_d[2] >= SEC_MS) begin
              beep = BEEP_COUNT; bs_d[2] = '0;
            end
          end else if (r_nz) begin
            if (bs_d[3] >= FAST_MS) begin
              beep = BEEP_COUNT; bs_d[3] = '0;
            end
          end
          if (sec_d >= SEC_MS) begin
            if (r_nz) begin
              sec_d = '0;
              if (rem_s_q != '0) begin
                rem_s_d = rem_s_q - 6'd1;
              end else begin
                rem_s_d = MIN_LIM - 6'd1;
                if (rem_m_q != '0) begin
                  rem_m_d = rem_m_q - 6'd1;
                end else begin
                  rem_m_d = MIN_LIM - 6'd1;
                  rem_h_d = rem_h_q - HW'(1);
                end
              end
            end else begin
              tone_d = 1'b1; ae_d = '0; beep = BEEP_ALARM;
              mode_d = MODE_ALARM; fe_d = '0;
            end
          end
        end
      end
      MODE_DISARMED: begin
        if (btn_i.a_pressed || btn_i.b_pressed || btn_i.c_pressed) begin
          beep = BEEP_CLICK; mode_d = MODE_SETUP; fs_d = '0;
          set_h_d = sav_h_q; set_m_d = sav_m_q; set_s_d = sav_s_q;
        end
      end
      MODE_ALARM: begin
        if (tone_q) begin
          ae_d = inc16(ae_q);
          if (ae_d >= cfg_i.long_beep) begin
            tone_d = 1'b0; mute = 1'b1;
          end
        end
        if (btn_i.a_pressed || btn_i.b_pressed || btn_i.c_pressed) begin
          if (tone_d) begin
            mute = 1'b1; tone_d = 1'b0;
          end
          beep = BEEP_CLICK; mode_d = MODE_SETUP; fs_d = '0;
          set_h_d = sav_h_q; set_m_d = sav_m_q; set_s_d = sav_s_q;
        end else begin
          fe_d = inc16(fe_q);
          if (fe_d > cfg_i.flash_int) begin
            fp_d = !fp_q; fe_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.mode      = mode_d;
    res_o.selection = fs_d;
    if (mode_d == MODE_SETUP) begin
      res_o.show_hours   = 5'(set_h_d);
      res_o.show_minutes = set_m_d;
      res_o.show_seconds = set_s_d;
    end else begin
      res_o.show_hours   = 5'(rem_h_d);
      res_o.show_minutes = rem_m_d;
      res_o.show_seconds = rem_s_d;
    end
    res_o.disarm_elapsed_ms = da_d ? de_d : 16'd0;
    res_o.beep_kind    = beep;
    res_o.speaker_mute = mute;
    res_o.flash_on     = (mode_d == MODE_ALARM) && fp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SETUP; fs_q <= '0;
      set_h_q <= '0; set_m_q <= '0; set_s_q <= '0;
      sav_h_q <= '0; sav_m_q <= '0; sav_s_q <= '0;
      rem_h_q <= '0; rem_m_q <= '0; rem_s_q <= '0;
      sec_q <= '0;
      for (int i = 0; i < 4; i++) bs_q[i] <= SEC_MS;
      da_q <= 1'b0; db_q <= BTN_NONE; de_q <= '0;
      tone_q <= 1'b0; ae_q <= '0; fp_q <= 1'b0; fe_q <= '0;
      bh_q <= '0; rep_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d; fs_q <= fs_d;
      set_h_q <= set_h_d; set_m_q <= set_m_d; set_s_q <= set_s_d;
      sav_h_q <= sav_h_d; sav_m_q <= sav_m_d; sav_s_q <= sav_s_d;
      rem_h_q <= rem_h_d; rem_m_q <= rem_m_d; rem_s_q <= rem_s_d;
      sec_q <= sec_d;
      for (int i = 0; i < 4; i++) bs_q[i] <= bs_d[i];
      da_q <= da_d; db_q <= db_d; de_q <= de_d;
      tone_q <= tone_d; ae_q <= ae_d; fp_q <= fp_d; fe_q <= fe_d;
      bh_q <= bh_d; rep_q <= rep_d;
    end
  end
endmodule

// ===== design/hold_to_cancel_countdown_timer.sv =====
// top level: config registers, timer core and output register
// Each input beat is one millisecond tick and yields exactly one result beat.
// The block takes one tick per clock cycle: the whole update of the timer state
// is one pass of logic between the state registers and the result register, and
// a new tick is accepted whenever the result register is empty or its beat is
// being taken in the same cycle. The remaining time is held as hours, minutes
// and seconds, so no divider sits in the path. Configuration writes take effect
// on the next tick.
module hold_to_cancel_countdown_timer #(
  parameter int HOUR_LIMIT = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hctc_in_if.sink     in_if,
  hctc_out_if.source  out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import hctc_pkg::*;

  cfg_t cfg;
  btn_t btn;
  res_t res, res_q;
  logic out_valid_q, step;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign step = in_if.valid && in_if.ready;

  assign btn = '{a_down: in_if.btn_a_down, b_down: in_if.btn_b_down,
                 c_down: in_if.btn_c_down, a_pressed: in_if.btn_a_pressed,
                 b_pressed: in_if.btn_b_pressed, c_pressed: in_if.btn_c_pressed};

  hctc_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .cfg_o(cfg)
  );

  hctc_core #(.HOUR_LIMIT(HOUR_LIMIT)) u_core (
    .clk_i, .rst_ni, .step_i(step), .btn_i(btn), .cfg_i(cfg), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_if.valid             = out_valid_q;
  assign out_if.mode              = res_q.mode;
  assign out_if.selection         = res_q.selection;
  assign out_if.show_hours        = res_q.show_hours;
  assign out_if.show_minutes      = res_q.show_minutes;
  assign out_if.show_seconds      = res_q.show_seconds;
  assign out_if.disarm_elapsed_ms = res_q.disarm_elapsed_ms;
  assign out_if.beep_kind         = res_q.beep_kind;
  assign out_if.speaker_mute      = res_q.speaker_mute;
  assign out_if.flash_on          = res_q.flash_on;
endmodule

// ===== design/hctc_checker.sv =====
// port-level checks for the countdown timer, bound to the top level
`include "hold_to_cancel_countdown_timer_macros.svh"

module hctc_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  mode,
  input logic [15:0] disarm_elapsed_ms,
  input logic        speaker_mute,
  input logic        flash_on
);
  import hctc_pkg::*;

  logic stalled, flashing, counting, muting;

  assign stalled  = out_valid && !out_ready;
  assign flashing = out_valid && flash_on;
  assign counting = out_valid && disarm_elapsed_ms != 16'd0;
  assign muting   = out_valid && speaker_mute;

  // a stalled result beat keeps its mode
  `HCTC_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, stalled, out_valid && $stable(mode))
  // flashing only while the alarm is up
  `HCTC_ASSERT_IMP(a_flash_mode, clk_i, rst_ni, flashing, mode == MODE_ALARM)
  // a running disarm count only while disarming
  `HCTC_ASSERT_IMP(a_disarm_mode, clk_i, rst_ni, counting, mode == MODE_DISARMING)
  // mute comes with the alarm ending or going back to setup
  `HCTC_ASSERT_IMP(a_mute_mode, clk_i, rst_ni, muting, mode inside {MODE_ALARM, MODE_SETUP})
endmodule

bind hold_to_cancel_countdown_timer hctc_props u_hctc_props (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .mode(out_if.mode),
  .disarm_elapsed_ms(out_if.disarm_elapsed_ms),
  .speaker_mute(out_if.speaker_mute),
  .flash_on(out_if.flash_on)
);

// ===== bench/hctc_checker.sv =====
// scoreboard for the countdown timer: tick predictor plus per-field result compare
`timescale 1ns / 1ps

module hctc_checker import hctc_pkg::*; #(
  parameter int HOUR_LIMIT = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hctc_in_if          in_if,
  hctc_out_if         out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count,
  output int          pending,
  output int          n_results,
  output int          n_alarms,
  output int          n_disarms,
  output mode_e       pred_mode,
  output logic [1:0]  pred_sel,
  output logic [4:0]  pred_h,
  output logic [5:0]  pred_m,
  output logic [5:0]  pred_s
);

  logic [15:0] hold_ms, flash_ms, tone_ms, dhold_ms, drep_ms;

  mode_e       mode_q;
  logic [1:0]  sel_q;
  logic [4:0]  set_h, sav_h;
  logic [5:0]  set_m, set_s, sav_m, sav_s;
  logic [16:0] remain;
  logic [9:0]  sec_ms;
  logic [9:0]  since [4];
  logic        arm_on;
  btn_e        arm_btn;
  logic [15:0] arm_ms;
  logic        tone_on;
  logic [15:0] tone_el;
  logic        flash_q;
  logic [15:0] flash_el, bhold, brep;

  res_t        want_q [$];

  assign pred_mode = mode_q;
  assign pred_sel  = sel_q;
  assign pred_h    = set_h;
  assign pred_m    = set_m;
  assign pred_s    = set_s;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [9:0] sat_sec(input logic [9:0] v);
    return (v >= 10'd1000) ? 10'd1000 : v + 10'd1;
  endfunction

  function automatic int wrap_step(input int v, input int lim, input bit up);
    if (up) return (v + 1 >= lim) ? 0 : v + 1;
    return (v == 0 || v > lim) ? lim - 1 : v - 1;
  endfunction

  function automatic void step_field(input bit up);
    case (sel_q)
      2'd0: set_h = 5'(wrap_step(int'(set_h), HOUR_LIMIT, up));
      2'd1: set_m = 6'(wrap_step(int'(set_m), 60, up));
      2'd2: set_s = 6'(wrap_step(int'(set_s), 60, up));
      default: ;
    endcase
  endfunction

  function automatic void end_attempt(input mode_e nxt);
    arm_on  = 1'b0;
    arm_btn = BTN_NONE;
    arm_ms  = 16'd0;
    mode_q  = nxt;
  endfunction

  function automatic void leave_to_setup();
    mode_q = MODE_SETUP;
    set_h  = sav_h;
    set_m  = sav_m;
    set_s  = sav_s;
    sel_q  = 2'd0;
  endfunction

  function automatic void clear_model();
    hold_ms  = 16'd5000;
    flash_ms = 16'd200;
    tone_ms  = 16'd10000;
    dhold_ms = 16'd500;
    drep_ms  = 16'd100;
    mode_q   = MODE_SETUP;
    sel_q    = 2'd0;
    set_h = '0; set_m = '0; set_s = '0;
    sav_h = '0; sav_m = '0; sav_s = '0;
    remain   = '0;
    sec_ms   = '0;
    for (int i = 0; i < 4; i++) since[i] = 10'd1000;
    arm_on   = 1'b0;
    arm_btn  = BTN_NONE;
    arm_ms   = '0;
    tone_on  = 1'b0;
    tone_el  = '0;
    flash_q  = 1'b0;
    flash_el = '0;
    bhold    = '0;
    brep     = '0;
  endfunction

  // one millisecond tick of the timer
  function automatic res_t advance_tick(input btn_t b);
    beep_e       bk;
    logic        mute;
    logic        dec;
    logic [15:0] prev;
    logic [16:0] r;
    logic        any;
    btn_e        id;
    int          total;
    res_t        res;
    bk   = BEEP_NONE;
    mute = 1'b0;
    dec  = 1'b0;

    sec_ms = sat_sec(sec_ms);
    for (int i = 0; i < 4; i++) since[i] = sat_sec(since[i]);

    prev = bhold;
    if (b.b_down) begin
      bhold = sat16(prev);
      if (bhold >= dhold_ms) begin
        if (prev < dhold_ms) begin
          dec  = 1'b1;
          brep = '0;
        end else begin
          brep = sat16(brep);
          if (brep >= drep_ms) begin
            dec  = 1'b1;
            brep = '0;
          end
        end
      end
    end else begin
      bhold = '0;
      brep  = '0;
    end

    case (mode_q)
      MODE_SETUP: begin
        if (b.a_pressed) begin
          bk    = BEEP_CLICK;
          sel_q = (sel_q >= 2'd2) ? 2'd0 : sel_q + 2'd1;
        end
        if (b.b_pressed) begin
          bk = BEEP_CLICK;
          step_field(1'b1);
        end
        if (dec) step_field(1'b0);
        if (b.c_pressed) begin
          total = int'(set_h) * 3600 + int'(set_m) * 60 + int'(set_s);
          bk = BEEP_CLICK;
          if (total > 0) begin
            sav_h  = set_h;
            sav_m  = set_m;
            sav_s  = set_s;
            remain = 17'(total);
            mode_q = MODE_COUNT;
            sec_ms = '0;
            for (int i = 0; i < 4; i++) since[i] = 10'd1000;
            tone_on = 1'b0;
          end
        end
      end
      MODE_COUNT, MODE_DISARMING: begin
        any = b.a_down | b.b_down | b.c_down;
        id  = b.a_down ? BTN_A : (b.b_down ? BTN_B : (b.c_down ? BTN_C : BTN_NONE));
        if (any && !arm_on) begin
          bk      = BEEP_CLICK;
          arm_on  = 1'b1;
          arm_btn = id;
          arm_ms  = '0;
          mode_q  = MODE_DISARMING;
        end else if (!any && arm_on) begin
          end_attempt(MODE_COUNT);
        end else if (any && arm_on) begin
          if (id == arm_btn) begin
            arm_ms = sat16(arm_ms);
            if (arm_ms >= hold_ms) begin
              end_attempt(MODE_DISARMED);
              n_disarms++;
            end
          end else begin
            end_attempt(MODE_COUNT);
          end
        end
        if (mode_q == MODE_COUNT) begin
          r = remain;
          // beep schedule: minutes, then tens, then seconds, then every third of a second
          if (r > 17'd60) begin
            if (r % 60 == 0 && since[0] >= 10'd1000) begin bk = BEEP_COUNT; since[0] = '0; end
          end else if (r >= 17'd10) begin
            if (r % 10 == 0 && since[1] >= 10'd1000) begin bk = BEEP_COUNT; since[1] = '0; end
          end else if (r >= 17'd3) begin
            if (since[2] >= 10'd1000) begin bk = BEEP_COUNT; since[2] = '0; end
          end else if (r > 17'd0) begin
            if (since[3] >= 10'd333) begin bk = BEEP_COUNT; since[3] = '0; end
          end
          if (sec_ms >= 10'd1000) begin
            if (r > 17'd0) begin
              remain = r - 17'd1;
              sec_ms = '0;
            end else begin
              tone_on  = 1'b1;
              tone_el  = '0;
              bk       = BEEP_ALARM;
              mode_q   = MODE_ALARM;
              flash_el = '0;
              n_alarms++;
            end
          end
        end
      end
      MODE_DISARMED: begin
        if (b.a_pressed || b.b_pressed || b.c_pressed) begin
          bk = BEEP_CLICK;
          leave_to_setup();
        end
      end
      MODE_ALARM: begin
        if (tone_on) begin
          tone_el = sat16(tone_el);
          if (tone_el >= tone_ms) begin
            tone_on = 1'b0;
            mute    = 1'b1;
          end
        end
        if (b.a_pressed || b.b_pressed || b.c_pressed) begin
          if (tone_on) begin
            mute    = 1'b1;
            tone_on = 1'b0;
          end
          bk = BEEP_CLICK;
          leave_to_setup();
        end else begin
          flash_el = sat16(flash_el);
          if (flash_el > flash_ms) begin
            flash_q  = ~flash_q;
            flash_el = '0;
          end
        end
      end
      default: ;
    endcase

    res.mode      = mode_q;
    res.selection = sel_q;
    if (mode_q == MODE_SETUP) begin
      res.show_hours   = set_h;
      res.show_minutes = set_m;
      res.show_seconds = set_s;
    end else begin
      res.show_hours   = 5'(int'(remain) / 3600);
      res.show_minutes = 6'((int'(remain) % 3600) / 60);
      res.show_seconds = 6'(int'(remain) % 60);
    end
    res.disarm_elapsed_ms = arm_on ? arm_ms : 16'd0;
    res.beep_kind         = bk;
    res.speaker_mute      = mute;
    res.flash_on          = (mode_q == MODE_ALARM) && flash_q;
    return res;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("result %0d: %s is %0d, predicted %0d", n_results, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    btn_t b;
    res_t w;
    if (!rst_ni) begin
      clear_model();
      want_q.delete();
      pending    = 0;
      fail_count = 0;
      n_results  = 0;
      n_alarms   = 0;
      n_disarms  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DISARM_HOLD: hold_ms  = cfg_wdata_i;
          CFG_FLASH_INT:   flash_ms = cfg_wdata_i;
          CFG_LONG_BEEP:   tone_ms  = cfg_wdata_i;
          CFG_DEC_HOLD:    dhold_ms = cfg_wdata_i;
          CFG_DEC_REPEAT:  drep_ms  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (want_q.size() == 0) begin
          $display("result %0d: beat with nothing predicted", n_results);
          fail_count++;
        end else begin
          w = want_q.pop_front();
          if (out_if.mode !== w.mode) report("mode", out_if.mode, w.mode);
          if (out_if.selection !== w.selection)
            report("selection", out_if.selection, w.selection);
          if (out_if.show_hours !== w.show_hours)
            report("show_hours", out_if.show_hours, w.show_hours);
          if (out_if.show_minutes !== w.show_minutes)
            report("show_minutes", out_if.show_minutes, w.show_minutes);
          if (out_if.show_seconds !== w.show_seconds)
            report("show_seconds", out_if.show_seconds, w.show_seconds);
          if (out_if.disarm_elapsed_ms !== w.disarm_elapsed_ms)
            report("disarm_elapsed_ms", out_if.disarm_elapsed_ms, w.disarm_elapsed_ms);
          if (out_if.beep_kind !== w.beep_kind)
            report("beep_kind", out_if.beep_kind, w.beep_kind);
          if (out_if.speaker_mute !== w.speaker_mute)
            report("speaker_mute", out_if.speaker_mute, w.speaker_mute);
          if (out_if.flash_on !== w.flash_on)
            report("flash_on", out_if.flash_on, w.flash_on);
        end
        n_results++;
      end
      if (in_if.valid && in_if.ready) begin
        b.a_down    = in_if.btn_a_down;
        b.b_down    = in_if.btn_b_down;
        b.c_down    = in_if.btn_c_down;
        b.a_pressed = in_if.btn_a_pressed;
        b.b_pressed = in_if.btn_b_pressed;
        b.c_pressed = in_if.btn_c_pressed;
        want_q.push_back(advance_tick(b));
      end
      pending = want_q.size();
    end
  end

endmodule

// ===== bench/hold_to_cancel_countdown_timer_tb.sv =====
// testbench top for the countdown timer: clock, reset, tick stimulus and verdict
`timescale 1ns / 1ps

module hold_to_cancel_countdown_timer_tb;
  import hctc_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;

  int          fail_count, pending, n_results, n_alarms, n_disarms;
  mode_e       pred_mode;
  logic [1:0]  pred_sel;
  logic [4:0]  pred_h;
  logic [5:0]  pred_m, pred_s;

  int          n_sent;
  int          n_settings;
  int          cur_hold;
  bit          calm;
  bit          valid_up;

  hctc_in_if  in_ch ();
  hctc_out_if out_ch ();

  hold_to_cancel_countdown_timer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  hctc_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count  (fail_count),
    .pending     (pending),
    .n_results   (n_results),
    .n_alarms    (n_alarms),
    .n_disarms   (n_disarms),
    .pred_mode   (pred_mode),
    .pred_sel    (pred_sel),
    .pred_h      (pred_h),
    .pred_m      (pred_m),
    .pred_s      (pred_s)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("timeout");
    $display("FAIL hold_to_cancel_countdown_timer");
    $finish;
  end

  // result side stalls in random bursts while calm is clear
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  function automatic btn_t mk(input bit ad, bd, cd, ap, bp, cp);
    btn_t b;
    b.a_down = ad; b.b_down = bd; b.c_down = cd;
    b.a_pressed = ap; b.b_pressed = bp; b.c_pressed = cp;
    return b;
  endfunction

  function automatic btn_t noise(input bit allow_c);
    btn_t b;
    b = btn_t'(6'($urandom_range(0, 63)));
    if (!allow_c) b.c_pressed = 1'b0;
    return b;
  endfunction

  task automatic send_tick(input btn_t b);
    in_ch.valid         <= 1'b1;
    in_ch.btn_a_down    <= b.a_down;
    in_ch.btn_b_down    <= b.b_down;
    in_ch.btn_c_down    <= b.c_down;
    in_ch.btn_a_pressed <= b.a_pressed;
    in_ch.btn_b_pressed <= b.b_pressed;
    in_ch.btn_c_pressed <= b.c_pressed;
    valid_up = 1'b1;
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    n_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // stop sending until every predicted beat has come back
  task automatic settle();
    if (valid_up) begin
      in_ch.valid <= 1'b0;
      valid_up = 1'b0;
    end
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input int hold, flash, tone, dhold, drep);
    int vals [5];
    vals = '{hold, flash, tone, dhold, drep};
    settle();
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_idx_i   <= 3'(i);
      cfg_wdata_i <= 16'(vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_hold = hold;
    n_settings++;
  endtask

  task automatic hold_button(input int which, input int n);
    btn_t b;
    repeat (n) begin
      b = mk(which == 0, which == 1, which == 2, $urandom_range(0, 1),
             $urandom_range(0, 1), $urandom_range(0, 1));
      send_tick(b);
    end
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(mk(0, 0, 0, 0, 0, 0));
  endtask

  // drive the timer back to setup from wherever it is
  task automatic finish_session(input bit wait_alarm);
    forever begin
      settle();
      case (pred_mode)
        MODE_SETUP: return;
        MODE_COUNT: begin
          if (!wait_alarm && cur_hold <= 400 && $urandom_range(0, 2) == 0) begin
            hold_button($urandom_range(0, 2), cur_hold + 1);
          end else begin
            if (!wait_alarm && $urandom_range(0, 1) == 1) begin
              hold_button(0, $urandom_range(1, 6));
              hold_button($urandom_range(1, 2), $urandom_range(1, 6));
            end
            idle_ticks($urandom_range(20, 200));
          end
        end
        MODE_ALARM: begin
          repeat ($urandom_range(0, 300)) send_tick(mk($urandom_range(0, 1),
            $urandom_range(0, 1), $urandom_range(0, 1), 0, 0, 0));
          send_tick(mk(0, 0, 0, $urandom_range(0, 1), 1, $urandom_range(0, 1)));
        end
        MODE_DISARMED: begin
          if ($urandom_range(0, 1)) idle_ticks($urandom_range(1, 5));
          send_tick(mk($urandom_range(0, 1), 0, $urandom_range(0, 1), 1,
                       $urandom_range(0, 1), $urandom_range(0, 1)));
        end
        default: idle_ticks(1);
      endcase
    end
  endtask

  task automatic setup_edits(input bit allow_c);
    int n;
    n = $urandom_range(2, 10);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0: send_tick(mk(0, 0, 0, 1, 0, 0));
        1: send_tick(mk(0, 0, 0, 0, 1, 0));
        2: begin
          send_tick(mk(0, 1, 0, 0, 1, 0));
          repeat ($urandom_range(1, 60)) send_tick(mk(0, 1, 0, 0, 0, 0));
        end
        3: send_tick(noise(allow_c));
        default: idle_ticks($urandom_range(1, 4));
      endcase
    end
  endtask

  task automatic goto_value(input int field, input int val);
    settle();
    while (pred_sel != 2'(field)) begin
      send_tick(mk(0, 0, 0, 1, 0, 0));
      settle();
    end
    while ((field == 0 ? int'(pred_h) : field == 1 ? int'(pred_m) : int'(pred_s)) != val)
    begin
      send_tick(mk(0, 0, 0, 0, 1, 0));
      settle();
    end
  endtask

  task automatic arm_at(input int h, input int m, input int s);
    goto_value(0, h);
    goto_value(1, m);
    goto_value(2, s);
    send_tick(mk(0, 0, 1, 0, 0, 1));
  endtask

  task automatic alarm_session();
    setup_edits(1'b0);
    finish_session(1'b0);
    arm_at(0, 0, 1);
    finish_session(1'b1);
  endtask

  task automatic session();
    setup_edits(cur_hold <= 400);
    finish_session(1'b0);
    if (cur_hold <= 400) begin
      case ($urandom_range(0, 4))
        0: arm_at(0, 0, 2);
        1: arm_at(0, 0, 5);
        2: arm_at(0, 0, 50);
        3: arm_at(0, 2, 0);
        default: arm_at($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
      endcase
      finish_session(1'b0);
    end
  endtask

  task automatic phase_body(input bit with_alarm);
    int start;
    start = n_sent;
    if (with_alarm) alarm_session();
    while (n_sent - start < 150) session();
  endtask

  task automatic directed();
    send_tick(mk(0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 1, 0, 0, 1));   // arm with zero total only clicks
    send_tick(mk(0, 0, 0, 1, 0, 0));
    send_tick(mk(0, 0, 0, 1, 0, 0));
    send_tick(mk(0, 0, 0, 1, 0, 0));   // selection wraps back to hours
    send_tick(mk(0, 0, 0, 0, 1, 0));
    send_tick(mk(0, 0, 0, 1, 0, 0));
    send_tick(mk(0, 0, 0, 0, 1, 0));
    send_tick(mk(1, 1, 1, 1, 1, 1));   // every press at once, arms
    send_tick(mk(1, 0, 0, 0, 0, 0));
    send_tick(mk(0, 1, 0, 0, 0, 0));  // switching buttons resumes the count
    send_tick(mk(0, 0, 0, 0, 0, 0));
    send_tick(mk(0, 0, 1, 0, 0, 0));
    send_tick(mk(0, 0, 0, 0, 0, 0));
    finish_session(1'b0);
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_DISARM_HOLD;
    cfg_wdata_i         = '0;
    in_ch.valid         = 1'b0;
    in_ch.btn_a_down    = 1'b0;
    in_ch.btn_b_down    = 1'b0;
    in_ch.btn_c_down    = 1'b0;
    in_ch.btn_a_pressed = 1'b0;
    in_ch.btn_b_pressed = 1'b0;
    in_ch.btn_c_pressed = 1'b0;
    n_sent     = 0;
    n_settings = 0;
    cur_hold   = 5000;
    calm       = 1'b0;
    valid_up   = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_cfg(20, 3, 50, 5, 2);
    directed();
    phase_body(1'b1);
    apply_cfg(1, 1, 1, 1, 1);
    phase_body(1'b0);
    apply_cfg($urandom_range(2, 40), $urandom_range(1, 20), $urandom_range(1, 300),
              $urandom_range(1, 30), $urandom_range(1, 10));
    phase_body(1'b0);
    apply_cfg(65535, 65535, 65535, 65535, 65535);
    phase_body(1'b0);
    calm = 1'b1;
    apply_cfg($urandom_range(2, 40), $urandom_range(1, 20), $urandom_range(1, 300),
              $urandom_range(1, 30), $urandom_range(1, 10));
    phase_body(1'b0);

    settle();
    repeat (10) @(posedge clk_i);
    $display("%0d ticks sent, %0d results checked over %0d register settings",
             n_sent, n_results, n_settings);
    $display("%0d alarms started, %0d disarms by hold", n_alarms, n_disarms);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS hold_to_cancel_countdown_timer");
    end else begin
      $display("FAIL hold_to_cancel_countdown_timer");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/hctc_pkg.sv
design/hctc_in_if.sv
design/hctc_out_if.sv
design/hctc_cfg.sv
design/hctc_core.sv
design/hold_to_cancel_countdown_timer.sv
design/hctc_checker.sv
bench/hctc_checker.sv
bench/hold_to_cancel_countdown_timer_tb.sv
